// ----- hw/rtl/rmh_pkg.sv -----
package rmh_pkg;

	localparam int unsigned MaxItemsDef = 1024;
	localparam int unsigned ValW = 32;
	localparam int unsigned SumW = 42;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUSH_START,
		ST_UP_RD,
		ST_UP_CMP,
		ST_POP_START,
		ST_DN_RD,
		ST_DN_CMP,
		ST_DN_SWAP,
		ST_DONE
	} heap_state_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_INS,
		C_INS_W,
		C_POP,
		C_POP_W,
		C_MOVE,
		C_MOVE_W,
		C_OUT
	} ctl_state_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic is_max;
		logic [ValW-1:0] value;
	} heap_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} heap_stat_t;

endpackage

// ----- hw/rtl/rmh_stream_if.sv -----
interface rmh_stream_if #(
	parameter int unsigned W = 1
);
	logic valid;
	logic ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/rmh_heap.sv -----
module rmh_heap import rmh_pkg::*; #(
	parameter int unsigned Depth = 514,
	parameter int unsigned AW = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  heap_cmd_t       cmd,
	input  logic [AW:0]     count,
	input  logic            clear,
	output heap_stat_t      stat,
	output logic [ValW-1:0] top,
	output logic [AW:0]     count_out,
	output logic [ValW-1:0] popped
);

	logic [ValW-1:0] mem [Depth];
	logic [ValW-1:0] rd_a_s1, rd_b_s1;
	logic [AW-1:0] rd_addr_a, rd_addr_b;
	logic [AW-1:0] wr_addr_a, wr_addr_b;
	logic [ValW-1:0] wr_data_a, wr_data_b;
	logic wr_en_a, wr_en_b;

	heap_state_t state_q, state_d;
	logic [AW:0] idx_q, idx_d, cnt_q, cnt_d;
	logic [ValW-1:0] cur_q, cur_d, top_q, top_d, pop_q, pop_d;
	logic is_max_q, is_max_d;
	logic [AW:0] kid_q, kid_d;
	logic [AW:0] parent, left, right;
	logic climb, settled;
	logic [ValW-1:0] kid_val;

	function automatic logic ahead(input logic mx, input logic [ValW-1:0] a,
		input logic [ValW-1:0] b);
		ahead = mx ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
	endfunction

	assign parent = (idx_q - 1'b1) >> 1;
	assign left = {idx_q[AW-1:0], 1'b1};
	assign right = left + 1'b1;
	assign climb = ahead(is_max_q, cur_q, rd_a_s1);
	assign settled = (kid_q == idx_q);
	assign kid_val = (kid_q == left) ? rd_a_s1 : rd_b_s1;

	always_ff @(posedge clk) begin
		if (wr_en_a) mem[wr_addr_a] <= wr_data_a;
		if (wr_en_b) mem[wr_addr_b] <= wr_data_b;
		rd_a_s1 <= mem[rd_addr_a];
		rd_b_s1 <= mem[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		cur_q <= cur_d;
		top_q <= top_d;
		pop_q <= pop_d;
		is_max_q <= is_max_d;
		kid_q <= kid_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.push) state_d = ST_PUSH_START;
				else if (cmd.pop) state_d = ST_POP_START;
			end
			ST_PUSH_START: state_d = (idx_q == '0) ? ST_DONE : ST_UP_RD;
			ST_UP_RD: state_d = ST_UP_CMP;
			ST_UP_CMP: state_d = (climb && parent != '0) ? ST_UP_RD : ST_DONE;
			ST_POP_START: state_d = ST_DN_RD;
			ST_DN_RD: state_d = (cnt_q == '0) ? ST_DONE : ST_DN_CMP;
			ST_DN_CMP: state_d = ST_DN_SWAP;
			ST_DN_SWAP: state_d = settled ? ST_DONE : ST_DN_RD;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		idx_d = idx_q;
		cnt_d = clear ? '0 : cnt_q;
		cur_d = cur_q;
		top_d = top_q;
		pop_d = pop_q;
		is_max_d = is_max_q;
		kid_d = kid_q;
		rd_addr_a = parent[AW-1:0];
		rd_addr_b = right[AW-1:0];
		wr_en_a = 1'b0;
		wr_en_b = 1'b0;
		wr_addr_a = idx_q[AW-1:0];
		wr_addr_b = kid_q[AW-1:0];
		wr_data_a = cur_q;
		wr_data_b = cur_q;
		case (state_q)
			ST_IDLE: begin
				is_max_d = cmd.is_max;
				if (cmd.push) begin
					cur_d = cmd.value;
					idx_d = count;
					cnt_d = count + 1'b1;
				end else if (cmd.pop) begin
					cnt_d = count - 1'b1;
					idx_d = '0;
				end
			end
			ST_PUSH_START: begin
				wr_en_a = 1'b1;
				if (idx_q == '0) top_d = cur_q;
			end
			ST_UP_CMP: begin
				if (climb) begin
					wr_en_a = 1'b1;
					wr_data_a = rd_a_s1;
					wr_en_b = 1'b1;
					wr_addr_b = parent[AW-1:0];
					idx_d = parent;
					if (parent == '0) top_d = cur_q;
				end
			end
			ST_POP_START: begin
				rd_addr_a = cnt_q[AW-1:0];
				pop_d = top_q;
			end
			ST_DN_RD: begin
				if (idx_q == '0) cur_d = rd_a_s1;
				rd_addr_a = left[AW-1:0];
			end
			ST_DN_CMP: begin
				rd_addr_a = left[AW-1:0];
				kid_d = idx_q;
				if (left < cnt_q && ahead(is_max_q, rd_a_s1, cur_q) &&
					!(right < cnt_q && ahead(is_max_q, rd_b_s1, rd_a_s1))) begin
					kid_d = left;
				end else if (right < cnt_q && ahead(is_max_q, rd_b_s1, cur_q)) begin
					kid_d = right;
				end
			end
			ST_DN_SWAP: begin
				wr_en_a = 1'b1;
				if (settled) begin
					if (idx_q == '0) top_d = cur_q;
				end else begin
					wr_data_a = kid_val;
					wr_en_b = 1'b1;
					idx_d = kid_q;
					if (idx_q == '0) top_d = kid_val;
				end
			end
			default: ;
		endcase
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign top = top_q;
	assign count_out = cnt_q;
	assign popped = pop_q;

endmodule

// ----- hw/rtl/rmh_ctrl.sv -----
module rmh_ctrl import rmh_pkg::*; #(
	parameter int unsigned MaxItems = MaxItemsDef,
	parameter int unsigned AW = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	rmh_stream_if.sink       in_ch,
	rmh_stream_if.source     out_ch
);

	localparam int unsigned CW = $clog2(MaxItems + 1);
	localparam int unsigned HeapDepth = MaxItems / 2 + 2;

	ctl_state_t st_q, st_d;
	logic full_q, lo_from_q;
	logic [ValW-1:0] med;
	logic [SumW-1:0] sum_q;
	heap_cmd_t cmd_lo, cmd_up;
	heap_stat_t stat_lo, stat_up;
	logic [ValW-1:0] top_lo, top_up, pop_lo, pop_up, samp_q;
	logic [AW:0] cnt_lo, cnt_up;
	logic clr, heaps_idle, over_cap, to_lo, lo_heavy, up_heavy;
	logic [CW:0] total;

	assign total = (CW+1)'(cnt_lo) + (CW+1)'(cnt_up);
	assign over_cap = (total >= (CW+1)'(MaxItems));
	assign to_lo = (cnt_lo == '0) || ($signed(samp_q) < $signed(top_lo));
	assign lo_heavy = (cnt_lo > cnt_up + 1'b1);
	assign up_heavy = (cnt_up > cnt_lo + 1'b1);
	assign heaps_idle = !stat_lo.busy && !stat_up.busy;
	assign clr = (st_q == C_IDLE) && in_ch.valid && in_ch.data[0];

	rmh_heap #(.Depth(HeapDepth), .AW(AW)) u_lo (
		.clk, .arst_n, .cmd(cmd_lo), .count(cnt_lo), .clear(clr), .stat(stat_lo),
		.top(top_lo), .count_out(cnt_lo), .popped(pop_lo));
	rmh_heap #(.Depth(HeapDepth), .AW(AW)) u_up (
		.clk, .arst_n, .cmd(cmd_up), .count(cnt_up), .clear(clr), .stat(stat_up),
		.top(top_up), .count_out(cnt_up), .popped(pop_up));

	always_comb begin
		st_d = st_q;
		case (st_q)
			C_IDLE: if (in_ch.valid) st_d = C_INS;
			C_INS: st_d = over_cap ? C_OUT : C_INS_W;
			C_INS_W: begin
				if (heaps_idle) st_d = (lo_heavy || up_heavy) ? C_POP : C_MOVE_W;
			end
			C_POP: st_d = C_POP_W;
			C_POP_W: if (heaps_idle) st_d = C_MOVE;
			C_MOVE: st_d = C_MOVE_W;
			C_MOVE_W: if (heaps_idle) st_d = C_OUT;
			C_OUT: if (out_ch.ready) st_d = C_IDLE;
			default: st_d = C_IDLE;
		endcase
	end

	always_comb begin
		cmd_lo = '{push: 1'b0, pop: 1'b0, is_max: 1'b1, value: samp_q};
		cmd_up = '{push: 1'b0, pop: 1'b0, is_max: 1'b0, value: samp_q};
		case (st_q)
			C_INS: begin
				if (!over_cap) begin
					if (to_lo) cmd_lo.push = 1'b1;
					else cmd_up.push = 1'b1;
				end
			end
			C_POP: begin
				if (lo_from_q) cmd_lo.pop = 1'b1;
				else cmd_up.pop = 1'b1;
			end
			C_MOVE: begin
				if (lo_from_q) begin
					cmd_up.push = 1'b1;
					cmd_up.value = pop_lo;
				end else begin
					cmd_lo.push = 1'b1;
					cmd_lo.value = pop_up;
				end
			end
			default: ;
		endcase
	end

	assign med = (cnt_lo == '0 && cnt_up == '0) ? '0 :
		(cnt_lo >= cnt_up) ? top_lo : top_up;

	assign in_ch.ready = (st_q == C_IDLE);
	assign out_ch.valid = (st_q == C_OUT);
	assign out_ch.data = {med, sum_q, full_q};

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			samp_q <= in_ch.data[ValW+1:2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			sum_q <= '0;
			full_q <= 1'b0;
			lo_from_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (clr) sum_q <= '0;
			else if (st_q == C_MOVE_W && heaps_idle) sum_q <= sum_q + SumW'($signed(med));
			if (st_q == C_INS) full_q <= over_cap;
			if (st_q == C_INS_W && heaps_idle) lo_from_q <= lo_heavy;
		end
	end

endmodule

// ----- hw/rtl/running_median_two_heaps.sv -----
// Channel | Payload                              | Direction
// in_ch   | sample[33:2], start_req[0]           | sink
// out_ch  | median_value, median_sum, full_flag  | source
// One sample is handled at a time. Its result is offered once the insert and any
// rebalancing are done, or with no heap operation when the sample is dropped as full.
// How long that takes depends on the insert sift-up, level by level, and, when the
// halves differ by two, a sift-down pop and a second sift-up. Reset clears the counts
// and the sum; the heap memories need no clearing. A result waits in out_ch until taken,
// and in_ch is ready again in the cycle after that.
module running_median_two_heaps import rmh_pkg::*; #(
	parameter int unsigned MaxItems = MaxItemsDef
) (
	input  logic         clk,
	input  logic         arst_n,
	rmh_stream_if.sink   in_ch,
	rmh_stream_if.source out_ch
);

	localparam int unsigned AW = $clog2(MaxItems / 2 + 2);

	rmh_ctrl #(.MaxItems(MaxItems), .AW(AW)) u_ctrl (
		.clk, .arst_n, .in_ch, .out_ch);

endmodule

// ----- bench/tb_running_median_two_heaps.sv -----
module tb_running_median_two_heaps;
	import rmh_pkg::*;

	localparam int unsigned Cap = MaxItemsDef;
	localparam int unsigned HeapDepth = Cap / 2 + 2;

	typedef struct {
		logic [ValW-1:0] sample;
		logic            start_req;
	} sample_item_t;

	typedef struct {
		logic [ValW-1:0] median_value;
		logic [SumW-1:0] median_sum;
		logic            full_flag;
	} median_res_t;

	logic clk;
	logic arst_n;

	rmh_stream_if #(.W(ValW + 2)) in_ch ();
	rmh_stream_if #(.W(ValW + SumW + 1)) out_ch ();

	running_median_two_heaps DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	sample_item_t pending_samples[$];
	median_res_t expected_medians[$];
	int issued_cnt;
	int accepted_cnt;
	int total_items;
	int result_cnt;
	int full_cnt;
	int start_cnt;
	int error_cnt;
	bit stim_done;

	int lo_heap[HeapDepth];
	int hi_heap[HeapDepth];
	int lo_cnt;
	int hi_cnt;
	logic [SumW-1:0] run_sum;

	function automatic bit outranks(bit is_max, int a, int b);
		return is_max ? (a > b) : (a < b);
	endfunction

	function automatic void heap_insert(bit is_max, int v);
		int i;
		int p;
		int t;
		if (is_max) begin
			i = lo_cnt;
			lo_heap[i] = v;
			lo_cnt++;
			while (i > 0) begin
				p = (i - 1) / 2;
				if (!outranks(1'b1, lo_heap[i], lo_heap[p]))
					break;
				t = lo_heap[p]; lo_heap[p] = lo_heap[i]; lo_heap[i] = t;
				i = p;
			end
		end else begin
			i = hi_cnt;
			hi_heap[i] = v;
			hi_cnt++;
			while (i > 0) begin
				p = (i - 1) / 2;
				if (!outranks(1'b0, hi_heap[i], hi_heap[p]))
					break;
				t = hi_heap[p]; hi_heap[p] = hi_heap[i]; hi_heap[i] = t;
				i = p;
			end
		end
	endfunction

	function automatic int heap_extract(bit is_max);
		int h[HeapDepth];
		int n;
		int top;
		int i;
		int l;
		int best;
		int t;
		if (is_max) begin
			h = lo_heap; n = lo_cnt;
		end else begin
			h = hi_heap; n = hi_cnt;
		end
		top = h[0];
		n--;
		h[0] = h[n];
		i = 0;
		forever begin
			l = 2 * i + 1;
			best = i;
			if (l < n && outranks(is_max, h[l], h[best]))
				best = l;
			if (l + 1 < n && outranks(is_max, h[l + 1], h[best]))
				best = l + 1;
			if (best == i)
				break;
			t = h[best]; h[best] = h[i]; h[i] = t;
			i = best;
		end
		if (is_max) begin
			lo_heap = h; lo_cnt = n;
		end else begin
			hi_heap = h; hi_cnt = n;
		end
		return top;
	endfunction

	function automatic int median_now();
		if (lo_cnt == 0 && hi_cnt == 0)
			return 0;
		return (lo_cnt >= hi_cnt) ? lo_heap[0] : hi_heap[0];
	endfunction

	function automatic median_res_t predict_median(sample_item_t it);
		median_res_t r;
		int s;
		int m;
		s = $signed(it.sample);
		r.full_flag = 1'b0;
		if (it.start_req) begin
			lo_cnt = 0; hi_cnt = 0; run_sum = '0;
		end
		if (lo_cnt + hi_cnt >= Cap) begin
			r.full_flag = 1'b1;
		end else begin
			if (lo_cnt == 0 || s < lo_heap[0])
				heap_insert(1'b1, s);
			else
				heap_insert(1'b0, s);
			if (lo_cnt > hi_cnt + 1)
				heap_insert(1'b0, heap_extract(1'b1));
			if (hi_cnt > lo_cnt + 1)
				heap_insert(1'b1, heap_extract(1'b0));
			m = median_now();
			run_sum = run_sum + {{(SumW - ValW){m[31]}}, m};
		end
		r.median_value = median_now();
		r.median_sum = run_sum;
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at result %0d: %s", result_cnt, what);
		error_cnt++;
	endtask

	function automatic void add_sample(int v, bit st);
		sample_item_t it;
		it.sample = v;
		it.start_req = st;
		pending_samples.push_back(it);
	endfunction

	function automatic int rand_value(int mode);
		case (mode)
			0: return $urandom();
			1: return $signed($urandom_range(20)) - 10;
			2: return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
			default: return $signed($urandom_range(2000)) - 1000;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic bit quiet_phase();
		return accepted_cnt >= 300 && accepted_cnt < 550;
	endfunction

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			out_ch.ready <= 1'b0;
			issued_cnt <= 0;
		end else begin
			out_ch.ready <= quiet_phase() || $urandom_range(99) >= 15;
			if (issued_cnt == accepted_cnt) begin
				if (pending_samples.size() > 0 &&
						(quiet_phase() || $urandom_range(99) >= 15)) begin
					sample_item_t it;
					it = pending_samples.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.data <= {it.sample, 1'b0, it.start_req};
					issued_cnt <= issued_cnt + 1;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				sample_item_t it;
				it.sample = in_ch.data[ValW+1:2];
				it.start_req = in_ch.data[0];
				if (it.start_req)
					start_cnt++;
				expected_medians.push_back(predict_median(it));
				accepted_cnt <= accepted_cnt + 1;
			end
			if (out_ch.valid && out_ch.ready) begin
				median_res_t got;
				median_res_t want;
				{got.median_value, got.median_sum, got.full_flag} = out_ch.data;
				if (expected_medians.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					want = expected_medians.pop_front();
					if (got.median_value !== want.median_value)
						report_mismatch($sformatf("median_value %0d, expected %0d",
							$signed(got.median_value), $signed(want.median_value)));
					if (got.median_sum !== want.median_sum)
						report_mismatch($sformatf("median_sum %0d, expected %0d",
							$signed(got.median_sum), $signed(want.median_sum)));
					if (got.full_flag !== want.full_flag)
						report_mismatch($sformatf("full_flag %0b, expected %0b",
							got.full_flag, want.full_flag));
					if (want.full_flag)
						full_cnt++;
				end
				result_cnt++;
			end
		end
	end

	initial begin
		int n;
		int mode;
		accepted_cnt = 0;
		lo_cnt = 0;
		hi_cnt = 0;
		run_sum = '0;
		add_sample(32'h7fffffff, 1'b0);
		add_sample(32'h80000000, 1'b0);
		add_sample(0, 1'b0);
		add_sample(-1, 1'b0);
		add_sample(1, 1'b0);
		add_sample(5, 1'b0);
		add_sample(5, 1'b0);
		add_sample(5, 1'b0);
		add_sample(32'h80000000, 1'b1);
		add_sample(32'h80000000, 1'b0);
		add_sample(32'h7fffffff, 1'b0);
		add_sample(32'h7fffffff, 1'b0);
		add_sample(32'h7fffffff, 1'b0);
		add_sample(32'h7fffffff, 1'b1);
		add_sample(32'h80000000, 1'b0);
		add_sample(32'h55555555, 1'b1);
		add_sample(32'haaaaaaaa, 1'b0);
		for (int k = 3; k > -3; k--)
			add_sample(k, 1'b0);
		// Fill to capacity, then push past it and restart while full.
		add_sample(rand_value(0), 1'b1);
		for (int k = 1; k < Cap + 6; k++)
			add_sample(rand_value($urandom_range(3)), 1'b0);
		add_sample(rand_value(0), 1'b1);
		while (pending_samples.size() < 1750) begin
			n = $urandom_range(40, 1);
			mode = $urandom_range(3);
			add_sample(rand_value(mode), 1'b1);
			for (int k = 1; k < n; k++)
				add_sample(rand_value(($urandom_range(9) == 0) ? $urandom_range(3) : mode),
					$urandom_range(49) == 0);
		end
		total_items = pending_samples.size();
		stim_done = 1'b1;
		wait (accepted_cnt == total_items && expected_medians.size() == 0);
		repeat (100) @(posedge clk);
		$display("%0d samples sent, %0d restarts, %0d results checked, %0d dropped as full",
			total_items, start_cnt, result_cnt, full_cnt);
		if (error_cnt == 0 && expected_medians.size() == 0)
			$display("tb_running_median_two_heaps OK");
		else
			$display("tb_running_median_two_heaps NOT OK");
		$finish;
	end

	initial begin
		#8000000;
		$display("timeout with %0d results outstanding", expected_medians.size());
		$display("tb_running_median_two_heaps NOT OK");
		$finish;
	end
endmodule

// ----- filelist.f -----
hw/rtl/rmh_pkg.sv
hw/rtl/rmh_stream_if.sv
hw/rtl/rmh_heap.sv
hw/rtl/rmh_ctrl.sv
hw/rtl/running_median_two_heaps.sv
bench/tb_running_median_two_heaps.sv
